// ----- rtl/lspg_pkg.sv -----
// Shared types and constants of the LED strip pattern generator.
package lspg_pkg;

	localparam logic [2:0] MODE_FIXED  = 3'd0;
	localparam logic [2:0] MODE_FILL   = 3'd1;
	localparam logic [2:0] MODE_SLICE  = 3'd2;
	localparam logic [2:0] MODE_SNAKES = 3'd3;
	localparam logic [2:0] MODE_WAVE   = 3'd4;

	localparam logic [2:0] REG_MODE        = 3'd0;
	localparam logic [2:0] REG_FIXED_COLOR = 3'd1;
	localparam logic [2:0] REG_HUE         = 3'd2;
	localparam logic [2:0] REG_SATURATION  = 3'd3;
	localparam logic [2:0] REG_BRIGHTNESS  = 3'd4;
	localparam logic [2:0] REG_FIRST_LIT   = 3'd5;
	localparam logic [2:0] REG_LAST_LIT    = 3'd6;
	localparam logic [2:0] REG_STRIP_LEN   = 3'd7;

	localparam int CFG_DW = 24;

	localparam logic [9:0] HUE_LIMIT  = 10'd360;
	localparam logic [8:0] HUE_SECTOR = 9'd60;
	localparam logic [6:0] SAT_MAX    = 7'd100;
	localparam logic [5:0] WAVE_STEP  = 6'd24;
	localparam logic [5:0] WAVE_LEN   = 6'd15;

	localparam logic [5:0] RED_END     = 6'd10;
	localparam logic [5:0] GREEN_START = 6'd15;
	localparam logic [5:0] GREEN_END   = 6'd25;
	localparam logic [5:0] BLUE_START  = 6'd30;
	localparam logic [5:0] BLUE_END    = 6'd40;
	localparam logic [7:0] FULL_LEVEL  = 8'hff;

	// Reciprocals that make the divisions by 100 and 60 exact over the value ranges used.
	localparam logic [12:0] RECIP_100 = 13'd5243;
	localparam int          SHIFT_100 = 19;
	localparam logic [14:0] RECIP_60  = 15'd17477;
	localparam int          SHIFT_60  = 20;

	typedef struct packed {
		logic [2:0]  mode;
		logic [23:0] fixed_color;
		logic [8:0]  hue;
		logic [6:0]  saturation;
		logic [7:0]  brightness;
		logic [5:0]  first_lit;
		logic [5:0]  last_lit;
		logic [6:0]  strip_length;
	} cfg_t;

	typedef struct packed {
		logic        use_hsv;
		logic [8:0]  hue;
		logic [23:0] rgb;
		logic        last;
	} pix_req_t;

	typedef struct packed {
		logic busy;
		logic issue;
		logic last;
	} seq_stat_t;

endpackage

// ----- rtl/lspg_frame_seq.sv -----
// Frame sequencer: walks the LEDs of one frame and forms one pixel request per cycle while adv is high.
module lspg_frame_seq import lspg_pkg::*; #(
	parameter int LED_MAX = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [31:0] frame_time,
	input  cfg_t        cfg,
	input  logic        adv,
	output logic        req_valid,
	output pix_req_t    req,
	output seq_stat_t   stat
);

	localparam int LW = $clog2(LED_MAX + 1);
	localparam int IW = (LED_MAX > 1) ? $clog2(LED_MAX) : 1;
	localparam int XW = (IW > 6) ? IW : 6;
	localparam int EW = (LW > 6) ? LW : 6;

	logic          busy_q;
	logic [IW-1:0] idx_q;
	logic [IW-1:0] last_q;
	logic [5:0]    offset_q;
	logic [5:0]    start_q;

	logic          req_valid_s1;
	pix_req_t      req_s1;

	logic [LW-1:0] len_w;
	logic [EW-1:0] len_m1;
	logic [EW-1:0] end_w;
	logic [EW-1:0] last_w;
	logic [5:0]    start_w;
	logic          accept;
	logic          issue;
	logic          is_last;
	logic [5:0]    x;
	logic [9:0]    hue_sum;
	logic [9:0]    hue_sel;
	pix_req_t      req_w;

	always_comb begin
		len_w   = (cfg.strip_length > LED_MAX) ? LW'(LED_MAX) : LW'(cfg.strip_length);
		len_m1  = EW'(len_w) - EW'(1);
		end_w   = (EW'(cfg.last_lit) < len_m1) ? EW'(cfg.last_lit) : len_m1;
		last_w  = (cfg.mode == MODE_SLICE) ? end_w : len_m1;
		start_w = (cfg.first_lit < cfg.last_lit) ? cfg.first_lit : cfg.last_lit;
	end

	assign in_ready = !busy_q;
	assign accept   = in_valid && !busy_q;
	assign issue    = busy_q && adv;
	assign is_last  = (idx_q == last_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q   <= 1'b0;
			idx_q    <= '0;
			last_q   <= '0;
			offset_q <= '0;
			start_q  <= '0;
		end else if (accept) begin
			busy_q   <= (len_w != '0);
			idx_q    <= '0;
			last_q   <= IW'(last_w);
			offset_q <= frame_time[6:1];
			start_q  <= start_w;
		end else if (issue) begin
			if (is_last) begin
				busy_q <= 1'b0;
				idx_q  <= '0;
			end else begin
				idx_q <= idx_q + IW'(1);
			end
		end
	end

	always_comb begin
		x       = 6'(XW'(idx_q) + XW'(offset_q));
		hue_sum = {1'b0, cfg.hue} + 10'(x) * 10'(WAVE_STEP);
		hue_sel = (cfg.mode == MODE_WAVE && x < WAVE_LEN) ? hue_sum : {1'b0, cfg.hue};
		req_w.hue     = (hue_sel >= HUE_LIMIT) ? 9'd0 : hue_sel[8:0];
		req_w.last    = is_last;
		req_w.use_hsv = 1'b0;
		req_w.rgb     = '0;
		case (cfg.mode)
			MODE_FIXED: begin
				req_w.rgb = cfg.fixed_color;
			end
			MODE_FILL, MODE_WAVE: begin
				req_w.use_hsv = 1'b1;
			end
			MODE_SLICE: begin
				req_w.use_hsv = (XW'(idx_q) >= XW'(start_q));
			end
			MODE_SNAKES: begin
				if (x < RED_END) begin
					req_w.rgb[23:16] = FULL_LEVEL;
				end else if (x >= GREEN_START && x < GREEN_END) begin
					req_w.rgb[15:8] = FULL_LEVEL;
				end else if (x >= BLUE_START && x < BLUE_END) begin
					req_w.rgb[7:0] = FULL_LEVEL;
				end
			end
			default: begin
				req_w.rgb = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_valid_s1 <= 1'b0;
		end else if (adv) begin
			req_valid_s1 <= issue;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			req_s1 <= req_w;
		end
	end

	assign req_valid  = req_valid_s1;
	assign req        = req_s1;
	assign stat.busy  = busy_q;
	assign stat.issue = issue;
	assign stat.last  = is_last;

endmodule

// ----- rtl/lspg_hsv_pipe.sv -----
// Five-stage HSV-to-RGB pipeline that ends in the output register.
module lspg_hsv_pipe import lspg_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       adv,
	input  logic       req_valid,
	input  pix_req_t   req,
	input  cfg_t       cfg,
	output logic       out_valid,
	output logic [7:0] red,
	output logic [7:0] green,
	output logic [7:0] blue,
	output logic       last_pixel
);

	logic        valid_s2, valid_s3, valid_s4, valid_s5, valid_s6;
	logic        use_s2, use_s3, use_s4, use_s5;
	logic [23:0] rgb_s2, rgb_s3, rgb_s4, rgb_s5;
	logic        last_s2, last_s3, last_s4, last_s5, last_s6;
	logic [7:0]  v_s2, v_s3, v_s4, v_s5;
	logic [2:0]  sector_s2, sector_s3, sector_s4, sector_s5;
	logic [5:0]  hmod_s2, hmod_s3;
	logic [14:0] prod_s2;
	logic [7:0]  vmin_s3, vmin_s4, vmin_s5;
	logic [13:0] prod_s4;
	logic [7:0]  a_s5;
	logic [7:0]  red_s6, green_s6, blue_s6;

	logic [6:0]  sat_c;
	logic [2:0]  sector_w;
	logic [8:0]  hbase_w;
	logic [27:0] vmin_prod;
	logic [29:0] a_prod;
	logic [7:0]  diff_w;
	logic [7:0]  vinc, vdec;
	logic [7:0]  r_w, g_w, b_w;

	always_comb begin
		sat_c    = (cfg.saturation > SAT_MAX) ? SAT_MAX : cfg.saturation;
		sector_w = '0;
		for (int k = 1; k < 6; k++) begin
			if (req.hue >= 9'(k) * HUE_SECTOR) begin
				sector_w = 3'(k);
			end
		end
		hbase_w   = 9'(sector_w) * HUE_SECTOR;
		vmin_prod = 28'(prod_s2) * 28'(RECIP_100);
		diff_w    = v_s3 - vmin_s3;
		a_prod    = 30'(prod_s4) * 30'(RECIP_60);
		vinc      = vmin_s5 + a_s5;
		vdec      = v_s5 - a_s5;
		case (sector_s5)
			3'd0: begin r_w = v_s5;    g_w = vinc;    b_w = vmin_s5; end
			3'd1: begin r_w = vdec;    g_w = v_s5;    b_w = vmin_s5; end
			3'd2: begin r_w = vmin_s5; g_w = v_s5;    b_w = vinc;    end
			3'd3: begin r_w = vmin_s5; g_w = vdec;    b_w = v_s5;    end
			3'd4: begin r_w = vinc;    g_w = vmin_s5; b_w = v_s5;    end
			default: begin r_w = v_s5; g_w = vmin_s5; b_w = vdec;    end
		endcase
		if (!use_s5) begin
			r_w = rgb_s5[23:16];
			g_w = rgb_s5[15:8];
			b_w = rgb_s5[7:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
			valid_s6 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= req_valid;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
			valid_s5 <= valid_s4;
			valid_s6 <= valid_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			use_s2    <= req.use_hsv;
			rgb_s2    <= req.rgb;
			last_s2   <= req.last;
			v_s2      <= cfg.brightness;
			sector_s2 <= sector_w;
			hmod_s2   <= 6'(req.hue - hbase_w);
			prod_s2   <= 15'(SAT_MAX - sat_c) * 15'(cfg.brightness);

			use_s3    <= use_s2;
			rgb_s3    <= rgb_s2;
			last_s3   <= last_s2;
			v_s3      <= v_s2;
			sector_s3 <= sector_s2;
			hmod_s3   <= hmod_s2;
			vmin_s3   <= 8'(vmin_prod >> SHIFT_100);

			use_s4    <= use_s3;
			rgb_s4    <= rgb_s3;
			last_s4   <= last_s3;
			v_s4      <= v_s3;
			sector_s4 <= sector_s3;
			vmin_s4   <= vmin_s3;
			prod_s4   <= 14'(diff_w) * 14'(hmod_s3);

			use_s5    <= use_s4;
			rgb_s5    <= rgb_s4;
			last_s5   <= last_s4;
			v_s5      <= v_s4;
			sector_s5 <= sector_s4;
			vmin_s5   <= vmin_s4;
			a_s5      <= 8'(a_prod >> SHIFT_60);

			last_s6   <= last_s5;
			red_s6    <= r_w;
			green_s6  <= g_w;
			blue_s6   <= b_w;
		end
	end

	assign out_valid  = valid_s6;
	assign red        = red_s6;
	assign green      = green_s6;
	assign blue       = blue_s6;
	assign last_pixel = last_s6;

endmodule

// ----- rtl/led_strip_pattern_generator_top.sv -----
// Top level of the LED strip pattern generator: configuration registers and pipeline.
//
// Each transaction on the input channel (in_valid, in_ready, frame_time) is one frame
// request. The block answers with one pixel transaction per LED (in slice mode only
// up to last_lit) on the output channel (out_valid, out_ready, red, green, blue), in
// strip order, with last_pixel set on the final pixel. The pattern comes from the
// registers written through cfg_we, cfg_index and cfg_data; the user must write them
// only while no frame is in flight, as the block itself does not enforce this.
// Each issued pixel request passes the request register and the pipeline stages to the
// output register; pixels are delivered one per cycle while out_ready stays high. The
// next request is accepted at the earliest in the cycle after the last pixel is issued.
// A frame with zero length produces no pixels and leaves in_ready high.
// When out_ready is low and out_valid high, all stages and the pixel counter hold, so no
// pixel is lost or repeated. Reset clears the pipeline valid bits and the counter, and
// loads the registers with their defaults: all zero, last_lit 63 and strip_length 64.
module led_strip_pattern_generator_top import lspg_pkg::*; #(
	parameter int LED_MAX = 64
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [31:0]       frame_time,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [7:0]        red,
	output logic [7:0]        green,
	output logic [7:0]        blue,
	output logic              last_pixel,
	input  logic              cfg_we,
	input  logic [2:0]        cfg_index,
	input  logic [CFG_DW-1:0] cfg_data
);

	cfg_t      cfg_q;
	logic      adv;
	logic      req_valid;
	pix_req_t  req;
	seq_stat_t stat;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.mode         <= MODE_FIXED;
			cfg_q.fixed_color  <= '0;
			cfg_q.hue          <= '0;
			cfg_q.saturation   <= '0;
			cfg_q.brightness   <= '0;
			cfg_q.first_lit    <= '0;
			cfg_q.last_lit     <= 6'd63;
			cfg_q.strip_length <= 7'd64;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_MODE:        cfg_q.mode         <= cfg_data[2:0];
				REG_FIXED_COLOR: cfg_q.fixed_color  <= cfg_data[23:0];
				REG_HUE:         cfg_q.hue          <= cfg_data[8:0];
				REG_SATURATION:  cfg_q.saturation   <= cfg_data[6:0];
				REG_BRIGHTNESS:  cfg_q.brightness   <= cfg_data[7:0];
				REG_FIRST_LIT:   cfg_q.first_lit    <= cfg_data[5:0];
				REG_LAST_LIT:    cfg_q.last_lit     <= cfg_data[5:0];
				REG_STRIP_LEN:   cfg_q.strip_length <= cfg_data[6:0];
				default: begin
				end
			endcase
		end
	end

	assign adv = !out_valid || out_ready;

	lspg_frame_seq #(
		.LED_MAX(LED_MAX)
	) u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.frame_time(frame_time),
		.cfg       (cfg_q),
		.adv       (adv),
		.req_valid (req_valid),
		.req       (req),
		.stat      (stat)
	);

	lspg_hsv_pipe u_pipe (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.req_valid (req_valid),
		.req       (req),
		.cfg       (cfg_q),
		.out_valid (out_valid),
		.red       (red),
		.green     (green),
		.blue      (blue),
		.last_pixel(last_pixel)
	);

	a_frame_starts: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && cfg_q.strip_length != '0 |=> !in_ready)
		else $error("accepted frame did not start the pixel counter");

	a_frame_ends: assert property (@(posedge clk) disable iff (!arst_n)
		stat.issue && stat.last |=> !stat.busy && in_ready)
		else $error("pixel counter stayed busy after the last pixel");

	a_issue_moves: assert property (@(posedge clk) disable iff (!arst_n)
		stat.issue |=> req_valid)
		else $error("issued pixel did not reach the first stage");

endmodule
